/* hw/rtl/ccrc_pkg.sv */
package ccrc_pkg;

    localparam int unsigned CRC_W       = 32;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned COUNT_W     = 17;
    localparam int unsigned CFG_IDX_W   = 1;

    localparam logic [CRC_W-1:0]   CRC_SEED        = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0]   POLY_CASTAGNOLI = 32'h82F6_3B78;
    localparam logic [CRC_W-1:0]   POLY_ZLIB       = 32'hEDB8_8320;
    localparam logic [COUNT_W-1:0] CHUNK_LEN_RESET = 17'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHUNK_LENGTH = 1'b0,
        REG_CRC_VARIANT  = 1'b1
    } cfg_index_t;

    typedef enum logic {
        VARIANT_CASTAGNOLI = 1'b0,
        VARIANT_ZLIB       = 1'b1
    } crc_variant_t;

    // Reflected CRC update of one byte, LSB first.
    function automatic logic [CRC_W-1:0] fold_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int b = 0; b < BYTE_W; b++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* hw/rtl/chunked_crc32_checksum.sv */
// Channel | Direction | Ports                                   | Transfer when
// --------+-----------+-----------------------------------------+-------------------------
// input   | in        | s_valid, s_ready, s_data_byte, s_last_byte | s_valid && s_ready
// result  | out       | m_valid, m_ready, m_checksum, m_final_chunk | m_valid && m_ready
// config  | in        | cfg_we, cfg_index, cfg_data             | cfg_we (no wait)
//
// One byte per cycle sustained unless a stalled result blocks a closing byte:
// a transferred byte sits in the input register, is folded into the running CRC
// by the combinational byte update in the following cycle, and a closed chunk's
// checksum is loaded into the output register at the end of that same cycle.
// The CRC/count feedback loop is the byte update plus a 17-bit increment and compare.
// Reset (aresetn low, synchronous) seeds the CRC with all ones, clears the
// byte count and both valid flags, and loads chunk_length 512, Castagnoli.
// A stalled result only blocks bytes that would close another chunk; other
// bytes keep flowing and one more can wait in the input register.
module chunked_crc32_checksum (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ccrc_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic                          s_last_byte,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ccrc_pkg::CRC_W-1:0]    m_checksum,
    output logic                          m_final_chunk,

    input  logic                          cfg_we,
    input  logic [ccrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ccrc_pkg::COUNT_W-1:0]  cfg_data
);

    // Configuration registers
    logic [ccrc_pkg::COUNT_W-1:0] chunk_len_reg;
    ccrc_pkg::crc_variant_t       variant_reg;

    // Input register
    logic                         in_valid_reg;
    logic [ccrc_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                         in_last_reg;

    // Running state
    logic [ccrc_pkg::CRC_W-1:0]   crc_reg,   crc_next;
    logic [ccrc_pkg::COUNT_W-1:0] count_reg, count_next;

    // Output register
    logic                         out_valid_reg;
    logic [ccrc_pkg::CRC_W-1:0]   out_crc_reg;
    logic                         out_final_reg;

    logic [ccrc_pkg::CRC_W-1:0]   poly;
    logic [ccrc_pkg::CRC_W-1:0]   crc_folded;
    logic [ccrc_pkg::COUNT_W-1:0] count_inc;
    logic                         closes;
    logic                         out_free;
    logic                         proc;
    logic                         s_xfer;
    logic                         m_xfer;

    // ---------------------------------------------------------------
    // Configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_len_reg <= ccrc_pkg::CHUNK_LEN_RESET;
            variant_reg   <= ccrc_pkg::VARIANT_CASTAGNOLI;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ccrc_pkg::REG_CHUNK_LENGTH: chunk_len_reg <= cfg_data;
                ccrc_pkg::REG_CRC_VARIANT:  variant_reg   <= ccrc_pkg::crc_variant_t'(cfg_data[0]);
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Byte update and chunk close decision
    // ---------------------------------------------------------------
    assign poly       = (variant_reg == ccrc_pkg::VARIANT_ZLIB) ? ccrc_pkg::POLY_ZLIB
                                                                : ccrc_pkg::POLY_CASTAGNOLI;
    assign crc_folded = ccrc_pkg::fold_byte(crc_reg, in_byte_reg, poly);
    assign count_inc  = count_reg + 1'b1;   // wraps at 17 bits
    // A zero length closes on every byte since the compare always passes.
    assign closes     = in_last_reg || (count_inc >= chunk_len_reg);

    // Process the registered byte unless it closes a chunk while the result
    // slot is still held by an untaken checksum.
    assign m_xfer   = out_valid_reg && m_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign proc     = in_valid_reg && (!closes || out_free);

    assign s_ready  = !in_valid_reg || proc;
    assign s_xfer   = s_valid && s_ready;

    always_comb begin
        crc_next   = crc_reg;
        count_next = count_reg;
        if (proc) begin
            if (closes) begin
                crc_next   = ccrc_pkg::CRC_SEED;
                count_next = '0;
            end else begin
                crc_next   = crc_folded;
                count_next = count_inc;
            end
        end
    end

    // ---------------------------------------------------------------
    // Input register: load on a transfer, drop once processed
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // ---------------------------------------------------------------
    // Running CRC and chunk byte count
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= ccrc_pkg::CRC_SEED;
            count_reg <= '0;
        end else begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
        end
    end

    // ---------------------------------------------------------------
    // Output register: load a closed chunk's checksum, hold until taken
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc && closes) begin
            out_valid_reg <= 1'b1;
        end else if (m_xfer) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && closes) begin
            out_crc_reg   <= ~crc_folded;
            out_final_reg <= in_last_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_checksum    = out_crc_reg;
    assign m_final_chunk = out_final_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // A blocked byte stays in the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !proc) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("blocked byte lost from input register");

    // Closing a chunk reseeds the CRC and clears the count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && closes) |=> (crc_reg == ccrc_pkg::CRC_SEED && count_reg == '0))
        else $error("chunk close did not restart CRC state");

    // A new result only appears after a closing byte was processed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(proc && closes))
        else $error("result appeared without a closing byte");

    // A closing byte never overwrites a result that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> ($stable(out_crc_reg) && $stable(out_final_reg)))
        else $error("pending result overwritten");

    // The count only moves when a byte is processed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !proc |=> $stable(count_reg) && $stable(crc_reg))
        else $error("CRC state changed without a processed byte");

endmodule

/* sim/tb_chunked_crc32_checksum.sv */
`timescale 1ns / 100ps

module tb_chunked_crc32_checksum;
    import ccrc_pkg::*;

    // Cycles to let an uncounted byte leave the two-stage pipe before a register write.
    localparam int IDLE_SETTLE  = 4;
    localparam int END_SETTLE   = 8;
    localparam int RANDOM_BYTES = 550;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } feed_byte_t;

    typedef struct packed {
        logic [CRC_W-1:0] checksum;
        logic             final_chunk;
    } chunk_sum_t;

    // Receiver stall patterns, switched after a random span.
    typedef enum int {
        RDY_ALWAYS,
        RDY_MOSTLY,
        RDY_SPARSE,
        RDY_PERIODIC
    } rdy_mode_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_data_byte   = '0;
    logic                 s_last_byte   = 1'b0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [CRC_W-1:0]     m_checksum;
    logic                 m_final_chunk;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [COUNT_W-1:0]   cfg_data      = '0;

    // Predictor state: shadow configuration plus running CRC and byte count.
    logic [COUNT_W-1:0]   chunk_len_cfg = CHUNK_LEN_RESET;
    crc_variant_t         variant_cfg   = VARIANT_CASTAGNOLI;
    logic [CRC_W-1:0]     crc_state     = CRC_SEED;
    logic [COUNT_W-1:0]   byte_cnt      = '0;

    feed_byte_t           pending_bytes[$];
    chunk_sum_t           expected_sums[$];

    int        bytes_queued = 0;
    int        bytes_taken  = 0;
    int        sums_checked = 0;
    int        phases       = 0;
    int        errors       = 0;
    logic      in_taken     = 1'b0;
    int        burst_left   = 0;
    int        gap_left     = 0;
    rdy_mode_t rdy_mode     = RDY_ALWAYS;
    int        rdy_span     = 0;

    chunked_crc32_checksum uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_checksum    (m_checksum),
        .m_final_chunk (m_final_chunk),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #(2_000_000);
        $display("FAILURE");
        $finish;
    end

    // Reflected CRC over one byte, LSB first: shift right, fold the polynomial
    // back in whenever a one drops off the bottom.
    function automatic logic [CRC_W-1:0] crc_fold_byte(logic [CRC_W-1:0] crc,
                                                       logic [BYTE_W-1:0] data,
                                                       logic [CRC_W-1:0] poly);
        logic [CRC_W-1:0] c;
        logic             lsb;
        c = crc;
        for (int i = 0; i < BYTE_W; i++) begin
            lsb = c[0] ^ data[i];
            c   = (c >> 1) ^ (poly & {CRC_W{lsb}});
        end
        return c;
    endfunction

    // Advance the predicted chunk by one accepted byte; close the chunk when
    // the buffer ends or the count reaches the configured length (a length
    // of zero closes on every byte since the count is always at least zero).
    task automatic crc_take_byte(logic [BYTE_W-1:0] data, logic last);
        logic [CRC_W-1:0] poly;
        poly      = (variant_cfg == VARIANT_ZLIB) ? POLY_ZLIB : POLY_CASTAGNOLI;
        crc_state = crc_fold_byte(crc_state, data, poly);
        byte_cnt  = byte_cnt + 1'b1;
        if (last || byte_cnt >= chunk_len_cfg) begin
            expected_sums.push_back('{checksum: ~crc_state, final_chunk: last});
            crc_state = CRC_SEED;
            byte_cnt  = '0;
        end
    endtask

    task automatic queue_byte(logic [BYTE_W-1:0] data, logic last);
        pending_bytes.push_back('{data: data, last: last});
        bytes_queued++;
    endtask

    // Write one register at a falling edge; the block latches it at the next rising edge.
    task automatic write_reg(cfg_index_t idx, logic [COUNT_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_CHUNK_LENGTH) begin
            chunk_len_cfg = val;
        end else begin
            variant_cfg = crc_variant_t'(val[0]);
        end
    endtask

    // Hold until every queued byte has transferred and every checksum came back,
    // then give a byte that closes nothing time to clear the pipe.
    task automatic wait_idle();
        do @(negedge aclk);
        while (bytes_taken != bytes_queued || expected_sums.size() != 0);
        repeat (IDLE_SETTLE) @(negedge aclk);
    endtask

    // Input driver: present queued bytes in bursts of random length, with
    // random gaps between bursts and some bursts running back to back.
    always @(negedge aclk) begin : byte_feed
        logic       nv;
        feed_byte_t item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // Drop valid only after the previous rising edge took the transfer.
            nv = s_valid && !in_taken;
            if (!nv) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_bytes.size() != 0) begin
                    item = pending_bytes.pop_front();
                    s_data_byte <= item.data;
                    s_last_byte <= item.last;
                    nv = 1'b1;
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 23);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            s_valid <= nv;
        end
    end

    // Result backpressure: switch among stall patterns, including stretches
    // with ready held high.
    always @(negedge aclk) begin : result_stall
        if (rdy_span == 0) begin
            rdy_mode = rdy_mode_t'($urandom_range(0, 3));
            rdy_span = $urandom_range(32, 200);
        end else begin
            rdy_span--;
        end
        case (rdy_mode)
            RDY_ALWAYS:   m_ready <= 1'b1;
            RDY_MOSTLY:   m_ready <= ($urandom_range(0, 3) != 0);
            RDY_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
            default:      m_ready <= (rdy_span[3:0] < 4);
        endcase
    end

    // Monitor: sample both channels at the rising edge, check the result
    // transfer against the oldest prediction, then predict from the input transfer.
    always @(posedge aclk) begin : chunk_monitor
        chunk_sum_t want;
        in_taken = aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (expected_sums.size() == 0) begin
                $error("unexpected checksum transfer: m_checksum %08h, m_final_chunk %0b",
                       m_checksum, m_final_chunk);
                errors++;
            end else begin
                want = expected_sums.pop_front();
                sums_checked++;
                if (m_checksum !== want.checksum) begin
                    $error("checksum mismatch: expected %08h, actual %08h",
                           want.checksum, m_checksum);
                    errors++;
                end
                if (m_final_chunk !== want.final_chunk) begin
                    $error("final_chunk mismatch: expected %0b, actual %0b",
                           want.final_chunk, m_final_chunk);
                    errors++;
                end
            end
        end
        if (in_taken) begin
            bytes_taken++;
            crc_take_byte(s_data_byte, s_last_byte);
        end
    end

    initial begin : stimulus
        int                 rand_bytes;
        int                 nbuf;
        int                 blen;
        logic               open_buf;
        logic [COUNT_W-1:0] len_val;
        rand_bytes = 0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings (512-byte chunks, Castagnoli): single-byte buffers at
        // both data extremes, then the standard check string "123456789".
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        for (int i = 0; i < 9; i++) queue_byte(BYTE_W'(8'h31 + i), i == 8);
        wait_idle();

        // zlib polynomial on the same extremes.
        write_reg(REG_CRC_VARIANT, 17'd1);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        wait_idle();

        // Zero length behaves like one: every byte closes a chunk.
        write_reg(REG_CHUNK_LENGTH, 17'd0);
        queue_byte(8'hA5, 1'b0);
        queue_byte(8'h5A, 1'b1);
        wait_idle();

        // Chunk fills exactly on the buffer's last byte, then leave two bytes open.
        write_reg(REG_CHUNK_LENGTH, 17'd3);
        queue_byte(8'h11, 1'b0);
        queue_byte(8'h22, 1'b0);
        queue_byte(8'h33, 1'b1);
        queue_byte(8'h44, 1'b0);
        queue_byte(8'h55, 1'b0);
        wait_idle();

        // Lower the length under the open count: the next byte closes the chunk.
        write_reg(REG_CHUNK_LENGTH, 17'd1);
        queue_byte(8'h66, 1'b0);
        queue_byte(8'h77, 1'b0);
        wait_idle();

        // Top of the 17-bit range, and a polynomial switch in the middle of a chunk.
        write_reg(REG_CHUNK_LENGTH, 17'h1FFFF);
        queue_byte(8'h01, 1'b0);
        wait_idle();
        write_reg(REG_CRC_VARIANT, 17'd0);
        queue_byte(8'hFE, 1'b1);
        wait_idle();

        write_reg(REG_CHUNK_LENGTH, 17'd65536);
        queue_byte(8'h80, 1'b1);
        wait_idle();
        phases = 7;

        // Random phases: new settings, then a few buffers. Most buffers end
        // with last_byte; some stay open so the next settings land mid-chunk.
        while (rand_bytes < RANDOM_BYTES) begin
            if (phases == 7 || $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0:       len_val = 17'd0;
                    1:       len_val = 17'd1;
                    2:       len_val = 17'd65536;
                    3:       len_val = 17'h1FFFF;
                    4:       len_val = COUNT_W'($urandom_range(65537, 131070));
                    5, 6:    len_val = COUNT_W'($urandom_range(2, 8));
                    7, 8:    len_val = COUNT_W'($urandom_range(9, 40));
                    default: len_val = CHUNK_LEN_RESET;
                endcase
                write_reg(REG_CHUNK_LENGTH, len_val);
            end
            if (phases == 7 || $urandom_range(0, 1) != 0) begin
                // Upper data bits are don't-care for the variant register; toggle them anyway.
                write_reg(REG_CRC_VARIANT, COUNT_W'($urandom_range(0, 131071)));
            end
            nbuf = $urandom_range(1, 4);
            for (int b = 0; b < nbuf; b++) begin
                blen     = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80)
                                                       : $urandom_range(1, 24);
                open_buf = ($urandom_range(0, 7) == 0);
                for (int i = 0; i < blen; i++) begin
                    queue_byte(BYTE_W'($urandom_range(0, 255)),
                               (i == blen - 1) && !open_buf);
                end
                rand_bytes += blen;
            end
            wait_idle();
            phases++;
        end

        repeat (END_SETTLE) @(negedge aclk);
        $display("Run covered %0d byte transfers over %0d configuration phases.",
                 bytes_taken, phases);
        $display("%0d chunk checksums compared, %0d mismatches.", sums_checked, errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
